// ===== hw/rtl/greedy_tour_edge_selector_assert.svh =====
// Assertion macros for the selector RTL, used by the sequencer gtes_seq.
`ifndef GREEDY_TOUR_EDGE_SELECTOR_ASSERT_SVH
`define GREEDY_TOUR_EDGE_SELECTOR_ASSERT_SVH

// Same-cycle implication.
`define GTES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gtes assertion failed");

// Next-cycle implication.
`define GTES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gtes assertion failed");

`endif

// ===== hw/rtl/gtes_pkg.sv =====
package gtes_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int ENDP_W           = 4;
    localparam int CNT_W            = 5;
    localparam int VCNT_W           = 5;
    localparam int MIN_VERTICES     = 3;
    localparam int DEG_W            = 2;

    localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(16);

    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_DEGREE = 2'd1;
    localparam logic [1:0] CAUSE_CYCLE  = 2'd2;
    localparam logic [1:0] CAUSE_DONE   = 2'd3;

    localparam logic CMD_CLEAR = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEG_A,
        ST_DEG_B,
        ST_WALK_A,
        ST_WALK_B,
        ST_DECIDE,
        ST_WR_PAR,
        ST_WR_DA,
        ST_WR_DB,
        ST_FIN
    } gtes_state_t;

    // Store control from the sequencer.
    typedef struct packed {
        logic clr;
        logic par_we;
        logic deg_we;
    } gtes_store_ctl_t;

    typedef struct packed {
        logic             accepted;
        logic             closes_tour;
        logic [1:0]       reject_cause;
        logic [CNT_W-1:0] edges_taken;
    } gtes_result_t;

endpackage

// ===== hw/rtl/gtes_if.sv =====
interface gtes_in_if;
    import gtes_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [ENDP_W-1:0] end_a;
    logic [ENDP_W-1:0] end_b;

    modport source (output valid, output cmd, output end_a, output end_b, input ready);
    modport sink   (input valid, input cmd, input end_a, input end_b, output ready);
endinterface

interface gtes_out_if;
    import gtes_pkg::*;

    logic             valid;
    logic             ready;
    logic             accepted;
    logic             closes_tour;
    logic [1:0]       reject_cause;
    logic [CNT_W-1:0] edges_taken;

    modport source (output valid, output accepted, output closes_tour,
                    output reject_cause, output edges_taken, input ready);
    modport sink   (input valid, input accepted, input closes_tour,
                    input reject_cause, input edges_taken, output ready);
endinterface

interface gtes_cfg_if;
    import gtes_pkg::*;

    logic              valid;
    logic              ready;
    logic [VCNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/greedy_tour_edge_selector.sv =====
// Greedy tour edge selector.
// Feed candidate edges in ascending length order on in_ch (cmd 1, end_a, end_b);
// cmd 0 clears the forest, degrees, edge count and done flag. Each input beat
// yields exactly one result beat on out_ch: accepted, closes_tour, reject_cause
// and edges_taken after the beat. cfg_ch writes vertex_count (always ready);
// write it only while no edge is in flight.
// A clear, or an edge beat after the tour is finished, goes straight to the
// finish state. Other edges read both end degrees; a degree or self-loop reject
// then finishes, while any other edge walks each end to its root, is decided,
// and if accepted writes the parent store (only when it merges two trees) and
// both degrees before it finishes. Each walk step is one read of the parent
// store, so the two walks, set by the tree depths of the ends, set the rate.
// One beat is processed at a time; the input is ready again once the result
// is in the output register, so a stalled receiver holds at most one result
// while the next beat is processed, and further progress waits on it.
// Reset: vertex_count 16, empty forest, zero degrees and count, no result.
module greedy_tour_edge_selector #(
    parameter int MAX_VERTICES = gtes_pkg::MAX_VERTICES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    gtes_in_if.sink           in_ch,
    gtes_out_if.source        out_ch,
    gtes_cfg_if.sink          cfg_ch
);
    import gtes_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);

    logic [VCNT_W-1:0] vcount_reg;

    gtes_result_t      out_data_reg;
    logic              out_valid_reg;

    gtes_result_t      result;
    gtes_store_ctl_t   ctl;
    logic              fin_valid;
    logic              slot_free;
    logic [VW-1:0]     rd_addr;
    logic [VW-1:0]     wr_addr;
    logic [VW-1:0]     par_wdata;
    logic [DEG_W-1:0]  deg_wdata;
    logic [VW-1:0]     par_q;
    logic [DEG_W-1:0]  deg_q;
    logic              seq_ready;

    // config register, taken on any beat
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VCNT_RESET;
        end
        else if (cfg_ch.valid)
        begin
            vcount_reg <= cfg_ch.data;
        end
    end

    // output register: loads when empty or draining this cycle
    assign slot_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_valid && slot_free)
        begin
            out_data_reg <= result;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.accepted     = out_data_reg.accepted;
    assign out_ch.closes_tour  = out_data_reg.closes_tour;
    assign out_ch.reject_cause = out_data_reg.reject_cause;
    assign out_ch.edges_taken  = out_data_reg.edges_taken;
    assign in_ch.ready         = seq_ready;

    gtes_seq #(
        .MAX_VERTICES (MAX_VERTICES),
        .VW           (VW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_ready     (seq_ready),
        .cmd          (in_ch.cmd),
        .end_a        (in_ch.end_a),
        .end_b        (in_ch.end_b),
        .vertex_count (vcount_reg),
        .slot_free    (slot_free),
        .fin_valid    (fin_valid),
        .result       (result),
        .ctl          (ctl),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .par_wdata    (par_wdata),
        .deg_wdata    (deg_wdata),
        .par_q        (par_q),
        .deg_q        (deg_q)
    );

    gtes_store #(
        .DEPTH     (MAX_VERTICES),
        .VW        (VW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .par_wdata (par_wdata),
        .deg_wdata (deg_wdata),
        .par_q     (par_q),
        .deg_q     (deg_q)
    );

endmodule

// ===== hw/rtl/gtes_store.sv =====
// Parent and degree stores; one read and one write port.
// Entries not written since the last clear read as their reset value.
module gtes_store #(
    parameter int DEPTH = gtes_pkg::MAX_VERTICES_DEF,
    parameter int VW    = $clog2(DEPTH)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  gtes_pkg::gtes_store_ctl_t ctl,
    input  logic [VW-1:0]            rd_addr,
    input  logic [VW-1:0]            wr_addr,
    input  logic [VW-1:0]            par_wdata,
    input  logic [gtes_pkg::DEG_W-1:0] deg_wdata,
    output logic [VW-1:0]            par_q,
    output logic [gtes_pkg::DEG_W-1:0] deg_q
);
    import gtes_pkg::*;

    logic [VW-1:0]    par_mem [DEPTH];
    logic [DEG_W-1:0] deg_mem [DEPTH];

    logic [DEPTH-1:0] par_vld_reg;
    logic [DEPTH-1:0] deg_vld_reg;

    logic [VW-1:0]    par_rd_reg;
    logic [DEG_W-1:0] deg_rd_reg;
    logic [VW-1:0]    addr_rd_reg;
    logic             par_vrd_reg;
    logic             deg_vrd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.par_we)
        begin
            par_mem[wr_addr] <= par_wdata;
        end
        if (ctl.deg_we)
        begin
            deg_mem[wr_addr] <= deg_wdata;
        end
        par_rd_reg  <= par_mem[rd_addr];
        deg_rd_reg  <= deg_mem[rd_addr];
        addr_rd_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            par_vld_reg <= '0;
            deg_vld_reg <= '0;
            par_vrd_reg <= 1'b0;
            deg_vrd_reg <= 1'b0;
        end
        else
        begin
            par_vrd_reg <= par_vld_reg[rd_addr];
            deg_vrd_reg <= deg_vld_reg[rd_addr];
            if (ctl.clr)
            begin
                par_vld_reg <= '0;
                deg_vld_reg <= '0;
            end
            else
            begin
                if (ctl.par_we)
                begin
                    par_vld_reg[wr_addr] <= 1'b1;
                end
                if (ctl.deg_we)
                begin
                    deg_vld_reg[wr_addr] <= 1'b1;
                end
            end
        end
    end

    // unwritten parent entry points to itself, unwritten degree is zero
    assign par_q = par_vrd_reg ? par_rd_reg : addr_rd_reg;
    assign deg_q = deg_vrd_reg ? deg_rd_reg : '0;

endmodule

// ===== hw/rtl/gtes_seq.sv =====
`include "greedy_tour_edge_selector_assert.svh"

// Sequencer: degree checks, two root walks, decision, store updates.
module gtes_seq #(
    parameter int MAX_VERTICES = gtes_pkg::MAX_VERTICES_DEF,
    parameter int VW           = $clog2(MAX_VERTICES)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [gtes_pkg::ENDP_W-1:0]   end_a,
    input  logic [gtes_pkg::ENDP_W-1:0]   end_b,
    input  logic [gtes_pkg::VCNT_W-1:0]   vertex_count,
    input  logic                          slot_free,
    output logic                          fin_valid,
    output gtes_pkg::gtes_result_t        result,
    output gtes_pkg::gtes_store_ctl_t     ctl,
    output logic [VW-1:0]                 rd_addr,
    output logic [VW-1:0]                 wr_addr,
    output logic [VW-1:0]                 par_wdata,
    output logic [gtes_pkg::DEG_W-1:0]    deg_wdata,
    input  logic [VW-1:0]                 par_q,
    input  logic [gtes_pkg::DEG_W-1:0]    deg_q
);
    import gtes_pkg::*;

    localparam logic [8:0] MAXV = 9'(MAX_VERTICES);

    // endpoint modulo MAX_VERTICES by repeated subtract (value below 16)
    function automatic logic [VW-1:0] reduce_vertex(input logic [ENDP_W-1:0] x);
        logic [8:0] v;
        v = 9'(x);
        for (int i = 0; i < 5; i++)
        begin
            if (v >= MAXV)
            begin
                v = v - MAXV;
            end
        end
        return v[VW-1:0];
    endfunction

    gtes_state_t      state_reg, state_next;
    logic [VW-1:0]    va_reg, va_next;
    logic [VW-1:0]    vb_reg, vb_next;
    logic [VW-1:0]    cur_reg, cur_next;
    logic [VW-1:0]    ra_reg, ra_next;
    logic [VW-1:0]    rb_reg, rb_next;
    logic [DEG_W-1:0] deg_a_reg, deg_a_next;
    logic [DEG_W-1:0] deg_b_reg, deg_b_next;
    logic [CNT_W-1:0] taken_reg, taken_next;
    logic             done_reg, done_next;
    logic             acc_reg, acc_next;
    logic             closes_reg, closes_next;
    logic [1:0]       cause_reg, cause_next;

    logic             in_fire;
    logic             walk_hit;
    logic             deg_lim;
    logic             same_root;
    logic [8:0]       eff_wide;
    logic [CNT_W-1:0] eff_count;
    logic             building;

    assign in_fire   = in_valid && in_ready;
    assign walk_hit  = (par_q == cur_reg);
    assign deg_lim   = (deg_a_reg >= DEG_W'(2)) || (deg_q >= DEG_W'(2));
    assign same_root = (ra_reg == rb_reg);

    always_comb
    begin
        eff_wide = 9'(vertex_count);
        if (eff_wide < 9'(MIN_VERTICES))
        begin
            eff_wide = 9'(MIN_VERTICES);
        end
        if (eff_wide > MAXV)
        begin
            eff_wide = MAXV;
        end
    end

    assign eff_count = eff_wide[CNT_W-1:0];
    assign building  = ({1'b0, taken_reg} + (CNT_W+1)'(1)) < {1'b0, eff_count};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (cmd == CMD_CLEAR || done_reg) ? ST_FIN : ST_DEG_A;
                end
            end
            ST_DEG_A:  state_next = ST_DEG_B;
            ST_DEG_B:  state_next = (deg_lim || va_reg == vb_reg) ? ST_FIN : ST_WALK_A;
            ST_WALK_A: state_next = walk_hit ? ST_WALK_B : ST_WALK_A;
            ST_WALK_B: state_next = walk_hit ? ST_DECIDE : ST_WALK_B;
            ST_DECIDE:
            begin
                if (building)
                begin
                    state_next = same_root ? ST_FIN : ST_WR_PAR;
                end
                else
                begin
                    state_next = same_root ? ST_WR_DA : ST_FIN;
                end
            end
            ST_WR_PAR: state_next = ST_WR_DA;
            ST_WR_DA:  state_next = ST_WR_DB;
            ST_WR_DB:  state_next = ST_FIN;
            ST_FIN:    state_next = slot_free ? ST_IDLE : ST_FIN;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        va_next     = va_reg;
        vb_next     = vb_reg;
        cur_next    = cur_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        deg_a_next  = deg_a_reg;
        deg_b_next  = deg_b_reg;
        taken_next  = taken_reg;
        done_next   = done_reg;
        acc_next    = acc_reg;
        closes_next = closes_reg;
        cause_next  = cause_reg;
        ctl         = '0;
        rd_addr     = cur_reg;
        wr_addr     = va_reg;
        par_wdata   = ra_reg;
        deg_wdata   = deg_a_reg + DEG_W'(1);
        in_ready    = 1'b0;
        fin_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                va_next  = reduce_vertex(end_a);
                vb_next  = reduce_vertex(end_b);
                rd_addr  = va_next;
                if (in_fire)
                begin
                    acc_next    = 1'b0;
                    closes_next = 1'b0;
                    cause_next  = CAUSE_NONE;
                    if (cmd == CMD_CLEAR)
                    begin
                        ctl.clr    = 1'b1;
                        taken_next = '0;
                        done_next  = 1'b0;
                    end
                    else if (done_reg)
                    begin
                        cause_next = CAUSE_DONE;
                    end
                end
            end
            ST_DEG_A:
            begin
                deg_a_next = deg_q;
                rd_addr    = vb_reg;
            end
            ST_DEG_B:
            begin
                deg_b_next = deg_q;
                rd_addr    = va_reg;
                cur_next   = va_reg;
                if (deg_lim)
                begin
                    cause_next = CAUSE_DEGREE;
                end
                else if (va_reg == vb_reg)
                begin
                    cause_next = CAUSE_CYCLE;
                end
            end
            ST_WALK_A:
            begin
                if (walk_hit)
                begin
                    ra_next  = cur_reg;
                    cur_next = vb_reg;
                    rd_addr  = vb_reg;
                end
                else
                begin
                    cur_next = par_q;
                    rd_addr  = par_q;
                end
            end
            ST_WALK_B:
            begin
                if (walk_hit)
                begin
                    rb_next = cur_reg;
                end
                else
                begin
                    cur_next = par_q;
                    rd_addr  = par_q;
                end
            end
            ST_DECIDE:
            begin
                if (building == same_root)
                begin
                    cause_next = CAUSE_CYCLE;
                end
                else
                begin
                    acc_next    = 1'b1;
                    closes_next = !building;
                    done_next   = !building;
                    taken_next  = taken_reg + CNT_W'(1);
                end
            end
            ST_WR_PAR:
            begin
                ctl.par_we = 1'b1;
                wr_addr    = rb_reg;
                par_wdata  = ra_reg;
            end
            ST_WR_DA:
            begin
                ctl.deg_we = 1'b1;
                wr_addr    = va_reg;
                deg_wdata  = deg_a_reg + DEG_W'(1);
            end
            ST_WR_DB:
            begin
                ctl.deg_we = 1'b1;
                wr_addr    = vb_reg;
                deg_wdata  = deg_b_reg + DEG_W'(1);
            end
            ST_FIN:
            begin
                fin_valid = 1'b1;
            end
            default:
            begin
                fin_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            taken_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            taken_reg <= taken_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg     <= va_next;
        vb_reg     <= vb_next;
        cur_reg    <= cur_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        deg_a_reg  <= deg_a_next;
        deg_b_reg  <= deg_b_next;
        acc_reg    <= acc_next;
        closes_reg <= closes_next;
        cause_reg  <= cause_next;
    end

    assign result.accepted     = acc_reg;
    assign result.closes_tour  = closes_reg;
    assign result.reject_cause = cause_reg;
    assign result.edges_taken  = taken_reg;

    `GTES_ASSERT_NOW(a_close_needs_accept, clk, rst_n, fin_valid && !acc_reg, !closes_reg)
    `GTES_ASSERT_NOW(a_accept_no_cause, clk, rst_n, fin_valid && acc_reg, cause_reg == CAUSE_NONE)
    `GTES_ASSERT_NOW(a_done_has_edges, clk, rst_n, done_reg, taken_reg != '0)
    `GTES_ASSERT_NEXT(a_clear_resets, clk, rst_n, in_fire && cmd == CMD_CLEAR, taken_reg == '0 && !done_reg)

endmodule

// ===== test/greedy_tour_edge_selector_tb.sv =====
`timescale 1ns / 1ps

module greedy_tour_edge_selector_tb;
    import gtes_pkg::*;

    // Rough total of input beats, the directed opening included.
    localparam int TOTAL_BEATS = 1550;
    localparam int MAX_V       = MAX_VERTICES_DEF;
    // An offered edge is the opposite of the clear command.
    localparam logic CMD_EDGE  = ~CMD_CLEAR;
    // Keep the log short if the block goes badly wrong.
    localparam int PRINT_CAP   = 100;

    // ------------------------------------------------------------------
    // Tour predictor and result checker.
    // Mirrors the forest, the degree counts, the edge count and the done
    // flag. Every accepted input beat pushes one expected result.
    // ------------------------------------------------------------------
    class tour_scoreboard;
        logic [ENDP_W-1:0] parent [MAX_V];
        logic [DEG_W-1:0]  degree [MAX_V];
        logic [CNT_W-1:0]  taken;
        bit                done;
        logic [VCNT_W-1:0] vcount;
        gtes_result_t      expected_q [$];
        int                errors;
        int                results_seen;

        function new();
            vcount       = VCNT_RESET;
            errors       = 0;
            results_seen = 0;
            clear_tour();
        endfunction

        function void clear_tour();
            for (int v = 0; v < MAX_V; v++)
            begin
                parent[v] = ENDP_W'(v);
                degree[v] = '0;
            end
            taken = '0;
            done  = 1'b0;
        endfunction

        function void set_vertex_count(logic [VCNT_W-1:0] value);
            vcount = value;
        endfunction

        // Register value clamped to the supported range.
        function int cities();
            int n;
            n = int'(vcount);
            if (n < MIN_VERTICES)
                n = MIN_VERTICES;
            if (n > MAX_V)
                n = MAX_V;
            return n;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [ENDP_W-1:0] tree_root(logic [ENDP_W-1:0] v);
            logic [ENDP_W-1:0] r;
            r = v;
            for (int s = 0; s < MAX_V; s++)
            begin
                if (parent[r] == r)
                    break;
                r = parent[r];
            end
            return r;
        endfunction

        // Random vertex below n that can still take an edge, or any vertex below n if none can.
        function logic [ENDP_W-1:0] open_vertex(int n);
            logic [ENDP_W-1:0] pool [$];
            for (int v = 0; v < n; v++)
                if (degree[v] < 2)
                    pool.push_back(ENDP_W'(v));
            if (pool.size() == 0)
                return ENDP_W'($urandom_range(0, n - 1));
            return pool[$urandom_range(0, pool.size() - 1)];
        endfunction

        function void note_edge(logic cmd, logic [ENDP_W-1:0] a, logic [ENDP_W-1:0] b);
            gtes_result_t      r;
            logic [ENDP_W-1:0] ra;
            logic [ENDP_W-1:0] rb;
            r = '0;
            r.reject_cause = CAUSE_NONE;
            if (cmd == CMD_CLEAR)
                clear_tour();
            else if (done)
                r.reject_cause = CAUSE_DONE;
            else if (degree[a] >= 2 || degree[b] >= 2)
                r.reject_cause = CAUSE_DEGREE;
            else if (a == b)
                r.reject_cause = CAUSE_CYCLE;
            else
            begin
                ra = tree_root(a);
                rb = tree_root(b);
                if (int'(taken) + 1 < cities())
                begin
                    // building phase: must join two trees
                    if (ra == rb)
                        r.reject_cause = CAUSE_CYCLE;
                    else
                    begin
                        r.accepted = 1'b1;
                        parent[rb] = ra;
                    end
                end
                else
                begin
                    // closing phase: must close the cycle
                    if (ra != rb)
                        r.reject_cause = CAUSE_CYCLE;
                    else
                    begin
                        r.accepted    = 1'b1;
                        r.closes_tour = 1'b1;
                        done          = 1'b1;
                    end
                end
                if (r.accepted)
                begin
                    degree[a] = degree[a] + 1'b1;
                    degree[b] = degree[b] + 1'b1;
                    taken     = taken + 1'b1;
                end
            end
            r.edges_taken = taken;
            expected_q.push_back(r);
        endfunction

        task flag_mismatch(string what);
            if (errors < PRINT_CAP)
                $display("[%0t] MISMATCH: %s", $realtime, what);
            errors++;
        endtask

        task check_result(gtes_result_t got);
            gtes_result_t want;
            if (expected_q.size() == 0)
            begin
                flag_mismatch($sformatf("result %0d arrived with no edge outstanding",
                                        results_seen));
                results_seen++;
                return;
            end
            want = expected_q.pop_front();
            if (got.accepted !== want.accepted)
                flag_mismatch($sformatf("result %0d accepted got %b want %b",
                                        results_seen, got.accepted, want.accepted));
            if (got.closes_tour !== want.closes_tour)
                flag_mismatch($sformatf("result %0d closes_tour got %b want %b",
                                        results_seen, got.closes_tour, want.closes_tour));
            if (got.reject_cause !== want.reject_cause)
                flag_mismatch($sformatf("result %0d reject_cause got %0d want %0d",
                                        results_seen, got.reject_cause, want.reject_cause));
            if (got.edges_taken !== want.edges_taken)
                flag_mismatch($sformatf("result %0d edges_taken got %0d want %0d",
                                        results_seen, got.edges_taken, want.edges_taken));
            results_seen++;
        endtask
    endclass

    logic clk;
    logic rst_n;

    gtes_in_if  in_ch ();
    gtes_out_if out_ch ();
    gtes_cfg_if cfg_ch ();

    greedy_tour_edge_selector i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    tour_scoreboard sb = new();

    // When set, that side runs back to back with no idle cycles.
    bit tx_calm;
    bit rx_calm;
    int beats_sent;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop. Its limit allows for the worst-case work, input gap and result
    // stall of every beat over the whole run, with a fivefold margin.
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input side. valid stays high across back-to-back beats; it is only
    // dropped when a gap is drawn or the stream pauses.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic cmd, input logic [ENDP_W-1:0] a,
                             input logic [ENDP_W-1:0] b);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= cmd;
        in_ch.end_a <= a;
        in_ch.end_b <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_edge(cmd, a, b);
        beats_sent++;
    endtask

    // Stop feeding and wait until every result is back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Register writes only happen with the block idle. Every beat yields a
    // result, so once the drain is over no edge is still in flight.
    task automatic write_vertex_count(input logic [VCNT_W-1:0] value);
        drain();
        repeat (4) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        sb.set_vertex_count(value);
    endtask

    // One random beat. Mostly edges between vertices that can still take
    // one, so tours actually get built and closed; the rest is noise.
    task automatic random_beat(input int n);
        int                pick;
        logic [ENDP_W-1:0] a;
        logic [ENDP_W-1:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            send_beat(CMD_CLEAR, ENDP_W'($urandom), ENDP_W'($urandom));
        else
        begin
            if (pick < 70)
            begin
                a = sb.open_vertex(n);
                b = sb.open_vertex(n);
            end
            else if (pick < 85)
            begin
                a = ENDP_W'($urandom_range(0, n - 1));
                b = ENDP_W'($urandom_range(0, n - 1));
            end
            else if (pick < 95)
            begin
                // full endpoint range, past vertex_count as well
                a = ENDP_W'($urandom);
                b = ENDP_W'($urandom);
            end
            else
            begin
                a = ENDP_W'($urandom_range(0, MAX_V - 1));
                b = a;
            end
            send_beat(CMD_EDGE, a, b);
        end
    endtask

    // Build one tour, then offer a few more edges past its end.
    task automatic run_tour();
        int n;
        int budget;
        int trail;
        n      = sb.cities();
        budget = 3 * n + 8;
        trail  = $urandom_range(1, 4);
        while (budget > 0 && trail > 0 && beats_sent < TOTAL_BEATS)
        begin
            if (sb.done)
                trail--;
            random_beat(n);
            budget--;
        end
    endtask

    // Short hand-picked sequence with four cities: both phases, every
    // reject cause, self loops, high endpoints, a duplicate closing edge.
    task automatic directed_tours();
        write_vertex_count(VCNT_W'(4));
        send_beat(CMD_CLEAR, 4'd15, 4'd15);
        send_beat(CMD_EDGE, 4'd0, 4'd1);
        send_beat(CMD_EDGE, 4'd1, 4'd2);
        send_beat(CMD_EDGE, 4'd2, 4'd1);   // degree limit on vertex 1
        send_beat(CMD_EDGE, 4'd3, 4'd3);   // self loop while building
        send_beat(CMD_EDGE, 4'd2, 4'd3);   // last edge of the building phase
        send_beat(CMD_EDGE, 4'd1, 4'd3);   // degree limit
        send_beat(CMD_EDGE, 4'd0, 4'd3);   // closes the tour
        send_beat(CMD_EDGE, 4'd15, 4'd14); // tour already finished
        send_beat(CMD_CLEAR, 4'd0, 4'd0);
        send_beat(CMD_EDGE, 4'd0, 4'd1);
        send_beat(CMD_EDGE, 4'd1, 4'd0);   // same tree while building
        send_beat(CMD_EDGE, 4'd15, 4'd14); // endpoints past vertex_count
        send_beat(CMD_EDGE, 4'd2, 4'd3);
        send_beat(CMD_EDGE, 4'd0, 4'd2);   // different trees while closing
        send_beat(CMD_EDGE, 4'd15, 4'd0);  // different trees again
        send_beat(CMD_EDGE, 4'd0, 4'd0);   // self loop while closing
        send_beat(CMD_EDGE, 4'd14, 4'd15); // same tree: closes
        send_beat(CMD_CLEAR, 4'd0, 4'd15);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall before each beat, then check it.
    // ------------------------------------------------------------------
    initial
    begin
        int           stall;
        gtes_result_t got;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = rx_calm ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            got.accepted     = out_ch.accepted;
            got.closes_tour  = out_ch.closes_tour;
            got.reject_cause = out_ch.reject_cause;
            got.edges_taken  = out_ch.edges_taken;
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int                phase;
        logic [VCNT_W-1:0] count_value;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        beats_sent   = 0;
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.cmd    <= CMD_CLEAR;
        in_ch.end_a  <= '0;
        in_ch.end_b  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset value of vertex_count is still in place here.
        send_beat(CMD_EDGE, 4'd0, 4'd15);
        directed_tours();

        // Each phase rewrites vertex_count with the block drained, so the
        // sender also pauses for all results once per phase. Skipping the
        // clear now and then changes the count in the middle of a tour.
        phase = 0;
        while (beats_sent < TOTAL_BEATS)
        begin
            case (phase)
                0: count_value = VCNT_W'(MIN_VERTICES);
                1: count_value = VCNT_W'(MAX_V);
                2: count_value = '0;
                3: count_value = '1;
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                        count_value = VCNT_W'($urandom);
                    else
                        count_value = VCNT_W'($urandom_range(MIN_VERTICES, MAX_V));
                end
            endcase
            write_vertex_count(count_value);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0)
                send_beat(CMD_CLEAR, ENDP_W'($urandom), ENDP_W'($urandom));
            run_tour();
            phase++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            sb.flag_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
